// File: rtl/mrpp_pkg.sv
`timescale 1ns / 1ps

package mrpp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned POS_W    = 4;

  // Value window: first packet character after '#' that belongs to the number.
  localparam int unsigned VALUE_START        = 4;
  localparam int unsigned VALUE_LENGTH_DEF   = 4;

  localparam logic [POS_W-1:0] POS_MAX = 4'd15;

  // Motor reply bytes
  localparam logic [BYTE_W-1:0] ADDR_A      = 8'h05;
  localparam logic [BYTE_W-1:0] ADDR_B      = 8'h06;
  localparam logic [BYTE_W-1:0] ADDR_C      = 8'h08;
  localparam logic [BYTE_W-1:0] ADDR_D      = 8'h09;
  localparam logic [BYTE_W-1:0] CODE_ARRIVE = 8'h3A;
  localparam logic [BYTE_W-1:0] CODE_HOMING = 8'h3B;
  localparam logic [BYTE_W-1:0] REPLY_TAIL  = 8'h6B;

  // Text packet bytes
  localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;

  // Status flag masks
  localparam logic [BYTE_W-1:0] IN_POS_MASK  = 8'h02;
  localparam logic [BYTE_W-1:0] HOME_BUSY_MASK = 8'h0C;

  typedef enum logic [PHASE_W-1:0] {
    PH_HUNT   = 3'd0,
    PH_CODE   = 3'd1,
    PH_STATUS = 3'd2,
    PH_TAIL   = 3'd3,
    PH_TEXT   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  arrival_status;
    logic [BYTE_W-1:0]  homing_status;
    logic               in_position;
    logic               homing_done;
    logic [PULSE_W-1:0] pulse_value;
    logic               pulse_updated;
    logic               status_updated;
    logic [PHASE_W-1:0] parser_phase;
  } mrpp_result_t;

endpackage

// File: rtl/mrpp_if.sv
`timescale 1ns / 1ps

interface mrpp_rx_if import mrpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrpp_res_if import mrpp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  arrival_status;
  logic [BYTE_W-1:0]  homing_status;
  logic               in_position;
  logic               homing_done;
  logic [PULSE_W-1:0] pulse_value;
  logic               pulse_updated;
  logic               status_updated;
  logic [PHASE_W-1:0] parser_phase;

  modport source (
    output valid, output arrival_status, output homing_status, output in_position,
    output homing_done, output pulse_value, output pulse_updated,
    output status_updated, output parser_phase, input ready
  );
  modport sink (
    input valid, input arrival_status, input homing_status, input in_position,
    input homing_done, input pulse_value, input pulse_updated,
    input status_updated, input parser_phase, output ready
  );
endinterface

// File: rtl/mrpp_atoi.sv
`timescale 1ns / 1ps

// Short decimal conversion: whitespace, optional sign, digits. Stops at the
// first character that does not fit or that was not received.
module mrpp_atoi import mrpp_pkg::*; #(
  parameter int unsigned VALUE_LENGTH = VALUE_LENGTH_DEF
) (
  input  logic [BYTE_W-1:0]       chars_i [VALUE_LENGTH],
  input  logic [VALUE_LENGTH-1:0] avail_i,
  output logic [PULSE_W-1:0]      value_o
);

  always_comb begin
    logic [PULSE_W-1:0] acc;
    logic               neg;
    logic               seen;
    logic               stop;
    logic [BYTE_W-1:0]  c;
    logic               is_digit;
    logic               is_ws;
    acc  = '0;
    neg  = 1'b0;
    seen = 1'b0;
    stop = 1'b0;
    for (int k = 0; k < int'(VALUE_LENGTH); k++) begin
      c        = chars_i[k];
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      if (!stop) begin
        if (!avail_i[k]) begin
          stop = 1'b1;
        end else if (is_digit) begin
          acc  = PULSE_W'(acc * PULSE_W'(10)) + PULSE_W'(c - CHAR_ZERO);
          seen = 1'b1;
        end else if (seen) begin
          stop = 1'b1;
        end else if (is_ws) begin
          seen = 1'b0;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          neg  = (c == CHAR_MINUS);
          seen = 1'b1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    value_o = neg ? PULSE_W'(-acc) : acc;
  end

endmodule

// File: rtl/mrpp_core.sv
`timescale 1ns / 1ps

// Parser state and per-byte update. res_o shows the state after byte_i.
module mrpp_core import mrpp_pkg::*; #(
  parameter int unsigned VALUE_LENGTH = VALUE_LENGTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  output mrpp_result_t      res_o
);

  phase_e             phase_q, phase_d;
  logic               homing_sel_q, homing_sel_d;
  logic [BYTE_W-1:0]  arrival_q, arrival_d;
  logic [BYTE_W-1:0]  homing_q, homing_d;
  logic [PULSE_W-1:0] pulse_q, pulse_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0]  chars_q [VALUE_LENGTH];

  logic [VALUE_LENGTH-1:0] char_we;
  logic [VALUE_LENGTH-1:0] avail;
  logic [PULSE_W-1:0]      dec_value;
  logic                    pulse_upd;
  logic                    status_upd;
  logic                    is_addr;

  assign is_addr = (byte_i == ADDR_A) || (byte_i == ADDR_B) ||
                   (byte_i == ADDR_C) || (byte_i == ADDR_D);

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_CODE: begin
        phase_d = (byte_i == CODE_ARRIVE || byte_i == CODE_HOMING) ? PH_STATUS : PH_HUNT;
      end
      PH_STATUS: phase_d = PH_TAIL;
      PH_TAIL: begin
        if (byte_i == REPLY_TAIL) phase_d = PH_HUNT;
      end
      PH_TEXT: begin
        if (byte_i == CHAR_BANG) phase_d = PH_HUNT;
      end
      default: begin
        if (byte_i == CHAR_HASH) phase_d = PH_TEXT;
        else if (is_addr)        phase_d = PH_CODE;
        else                     phase_d = PH_HUNT;
      end
    endcase
  end

  // datapath updates per phase
  always_comb begin
    homing_sel_d = homing_sel_q;
    arrival_d    = arrival_q;
    homing_d     = homing_q;
    pulse_d      = pulse_q;
    pos_d        = pos_q;
    char_we      = '0;
    pulse_upd    = 1'b0;
    status_upd   = 1'b0;
    unique case (phase_q)
      PH_CODE: begin
        if (byte_i == CODE_ARRIVE || byte_i == CODE_HOMING) begin
          homing_sel_d = (byte_i == CODE_HOMING);
        end
      end
      PH_STATUS: begin
        if (homing_sel_q) homing_d  = byte_i;
        else              arrival_d = byte_i;
        status_upd = 1'b1;
      end
      PH_TAIL: begin
        if (byte_i == REPLY_TAIL) homing_sel_d = 1'b0;
      end
      PH_TEXT: begin
        if (byte_i == CHAR_BANG) begin
          pulse_d   = dec_value;
          pulse_upd = 1'b1;
          pos_d     = '0;
        end else if (pos_q < POS_MAX) begin
          for (int k = 0; k < int'(VALUE_LENGTH); k++) begin
            char_we[k] = (pos_q == POS_W'(int'(VALUE_START) + k));
          end
          pos_d = pos_q + POS_W'(1);
        end
      end
      default: begin
        if (byte_i == CHAR_HASH) pos_d = '0;
      end
    endcase
  end

  for (genvar k = 0; k < int'(VALUE_LENGTH); k++) begin : g_win
    assign avail[k] = (pos_q > POS_W'(int'(VALUE_START) + k));

    always_ff @(posedge clk_i) begin
      if (step_i && char_we[k]) chars_q[k] <= byte_i;
    end
  end

  mrpp_atoi #(
    .VALUE_LENGTH(VALUE_LENGTH)
  ) u_atoi (
    .chars_i(chars_q),
    .avail_i(avail),
    .value_o(dec_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      homing_sel_q <= 1'b0;
      arrival_q    <= '0;
      homing_q     <= '0;
      pulse_q      <= '0;
      pos_q        <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      homing_sel_q <= homing_sel_d;
      arrival_q    <= arrival_d;
      homing_q     <= homing_d;
      pulse_q      <= pulse_d;
      pos_q        <= pos_d;
    end
  end

  always_comb begin
    res_o.arrival_status = arrival_d;
    res_o.homing_status  = homing_d;
    res_o.in_position    = |(arrival_d & IN_POS_MASK);
    res_o.homing_done    = ~|(homing_d & HOME_BUSY_MASK);
    res_o.pulse_value    = pulse_d;
    res_o.pulse_updated  = pulse_upd;
    res_o.status_updated = status_upd;
    res_o.parser_phase   = phase_d;
  end

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(pos_q) && $stable(pulse_q))
    else $error("parser state moved without a byte");

  a_status_to_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_STATUS |=> phase_q == PH_TAIL)
    else $error("status byte did not lead to tail wait");

  a_bang_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_TEXT && byte_i == CHAR_BANG |=> pos_q == '0 && phase_q == PH_HUNT)
    else $error("packet end did not clear position");

  a_pos_only_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q != PH_TEXT && byte_i != CHAR_HASH |=> $stable(pos_q))
    else $error("packet position moved outside a packet");

endmodule

// File: rtl/motor_reply_and_pulse_packet_parser.sv
`timescale 1ns / 1ps

// Motor reply and pulse packet parser.
//
// rx_i  : one received serial byte per transfer (valid/ready).
// res_o : one result per byte, in byte order: stored arrival and homing
//         status, in-position and homing-done flags, last packet value,
//         update strobes and the parser phase after that byte.
//
// A byte taken from rx_i lands in the input register; once the output
// register is free or being emptied it is parsed and its result is loaded
// into the output register, from which res_o shows it. Throughput is one
// byte per cycle while res_o takes every result: the per-byte update is a
// single pass between the two registers.
//
// When res_o stalls the output register holds its result, the input
// register holds one more byte, and rx_i.ready drops only while both are
// full; a transfer at res_o frees space in the same cycle.
//
// Reset clears both registers, returns to hunting and zeroes the stored
// statuses, the packet value and the packet position. Window characters
// are not cleared; only characters received in the current packet are read.
module motor_reply_and_pulse_packet_parser import mrpp_pkg::*; #(
  parameter int unsigned VALUE_LENGTH = VALUE_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrpp_rx_if.sink    rx_i,
  mrpp_res_if.source res_o
);

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_valid_q, out_valid_d;
  mrpp_result_t      out_q;
  mrpp_result_t      core_res;
  logic              rx_take;
  logic              advance;

  // Parse the held byte when the output register is free or being emptied.
  assign advance   = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign rx_take   = rx_i.valid && rx_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) in_byte_q <= rx_i.rx_byte;
    if (advance) out_q     <= core_res;
  end

  mrpp_core #(
    .VALUE_LENGTH(VALUE_LENGTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .byte_i(in_byte_q),
    .res_o (core_res)
  );

  assign res_o.valid          = out_valid_q;
  assign res_o.arrival_status = out_q.arrival_status;
  assign res_o.homing_status  = out_q.homing_status;
  assign res_o.in_position    = out_q.in_position;
  assign res_o.homing_done    = out_q.homing_done;
  assign res_o.pulse_value    = out_q.pulse_value;
  assign res_o.pulse_updated  = out_q.pulse_updated;
  assign res_o.status_updated = out_q.status_updated;
  assign res_o.parser_phase   = out_q.parser_phase;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("parsed byte produced no result");

  a_in_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("held byte lost before parsing");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |-> !advance)
    else $error("result overwritten while stalled");

endmodule

// File: dv/tb_motor_reply_and_pulse_packet_parser.sv
`timescale 1ns / 1ps

module tb_motor_reply_and_pulse_packet_parser;
  import mrpp_pkg::*;

  localparam int unsigned RAND_ITEMS  = 426;
  localparam int unsigned RESET_LEN   = 10;
  localparam int unsigned CALM_FROM   = 150;  // no idling on either side in this byte range
  localparam int unsigned CALM_TO     = 240;
  localparam int unsigned HOLD_AT     = 320;  // receiver holds off once this many bytes are in
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned DRAIN       = 16;   // extra wait after the last result
  localparam int unsigned STUCK_LIMIT = 1000;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;  // want holds a hand-written expectation
    mrpp_result_t      want;
  } stim_row_t;

  typedef enum int unsigned {CH_DIGIT, CH_BLANK, CH_SIGN, CH_ANY, CH_MIXED} char_kind_e;
  typedef enum int unsigned {SEQ_REPLY, SEQ_PACKET, SEQ_NOISE} seq_kind_e;

  localparam mrpp_result_t NO_RES = '0;
  localparam int unsigned DIR_N = 24;

  // Directed opening: both reply codes, a bad code, extreme status bytes,
  // a signed number after a prefix, and an empty packet.
  localparam stim_row_t DIRECTED [DIR_N] = '{
    {8'h00, 1'b1, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, PH_HUNT},
    {8'h05, 1'b1, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, PH_CODE},
    {8'h3A, 1'b0, NO_RES},
    {8'hFF, 1'b1, 8'hFF, 8'h00, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, PH_TAIL},
    {8'h6B, 1'b0, NO_RES},
    {8'h09, 1'b0, NO_RES},
    {8'h3B, 1'b0, NO_RES},
    {8'h0C, 1'b1, 8'hFF, 8'h0C, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1, PH_TAIL},
    {8'h00, 1'b0, NO_RES},
    {8'h6B, 1'b0, NO_RES},
    {8'h08, 1'b0, NO_RES},
    // bad code byte drops back to hunting, nothing stored
    {8'h77, 1'b1, 8'hFF, 8'h0C, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, PH_HUNT},
    // "#abcd-123!"
    {8'h23, 1'b0, NO_RES},
    {8'h61, 1'b0, NO_RES},
    {8'h62, 1'b0, NO_RES},
    {8'h63, 1'b0, NO_RES},
    {8'h64, 1'b0, NO_RES},
    {8'h2D, 1'b0, NO_RES},
    {8'h31, 1'b0, NO_RES},
    {8'h32, 1'b0, NO_RES},
    {8'h33, 1'b0, NO_RES},
    {8'h21, 1'b1, 8'hFF, 8'h0C, 1'b1, 1'b0, 16'hFF85, 1'b1, 1'b0, PH_HUNT},
    // "#!" : nothing in the value window, value is 0
    {8'h23, 1'b0, NO_RES},
    {8'h21, 1'b1, 8'hFF, 8'h0C, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0, PH_HUNT}
  };

  logic clk_i;
  logic rst_ni;

  mrpp_rx_if  rx_if ();
  mrpp_res_if res_if ();

  motor_reply_and_pulse_packet_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Parser state mirror
  phase_e             st_phase;
  logic               st_code_homing;
  logic [BYTE_W-1:0]  st_arrival;
  logic [BYTE_W-1:0]  st_homing;
  logic [PULSE_W-1:0] st_pulse;
  logic [POS_W-1:0]   st_pos;
  logic [BYTE_W-1:0]  st_win [4];

  logic [BYTE_W-1:0] byte_stream [$];
  mrpp_result_t      pending_results [$];
  int unsigned       n_in;
  int unsigned       n_out;
  int unsigned       stuck;
  int unsigned       mismatches;

  // Advances the mirror by one received byte and returns the result it must cause.
  function automatic mrpp_result_t parse_byte(input logic [BYTE_W-1:0] b);
    mrpp_result_t r;
    int unsigned  avail;
    int unsigned  i;
    int unsigned  acc;
    logic         neg;
    r = '0;
    case (st_phase)
      PH_CODE: begin
        if (b == CODE_ARRIVE || b == CODE_HOMING) begin
          st_code_homing = (b == CODE_HOMING);
          st_phase = PH_STATUS;
        end else begin
          st_phase = PH_HUNT;
        end
      end
      PH_STATUS: begin
        if (st_code_homing) st_homing = b;
        else st_arrival = b;
        r.status_updated = 1'b1;
        st_phase = PH_TAIL;
      end
      PH_TAIL: begin
        if (b == REPLY_TAIL) begin
          st_code_homing = 1'b0;
          st_phase = PH_HUNT;
        end
      end
      PH_TEXT: begin
        if (b == CHAR_BANG) begin
          // atoi over the window, stopping at the first byte not received
          avail = (st_pos > VALUE_START) ? st_pos - VALUE_START : 0;
          if (avail > VALUE_LENGTH_DEF) avail = VALUE_LENGTH_DEF;
          i = 0;
          acc = 0;
          neg = 1'b0;
          while (i < avail && (st_win[i] == CHAR_SPACE ||
                 (st_win[i] >= CHAR_TAB && st_win[i] <= CHAR_CR)))
            i++;
          if (i < avail && (st_win[i] == CHAR_PLUS || st_win[i] == CHAR_MINUS)) begin
            neg = (st_win[i] == CHAR_MINUS);
            i++;
          end
          while (i < avail && st_win[i] >= CHAR_ZERO && st_win[i] <= CHAR_NINE) begin
            acc = acc * 10 + st_win[i] - CHAR_ZERO;
            i++;
          end
          if (neg) acc = 0 - acc;
          st_pulse = acc[PULSE_W-1:0];
          r.pulse_updated = 1'b1;
          st_pos = '0;
          st_phase = PH_HUNT;
        end else if (st_pos < POS_MAX) begin
          if (st_pos >= VALUE_START && st_pos < VALUE_START + VALUE_LENGTH_DEF)
            st_win[st_pos - VALUE_START] = b;
          st_pos = st_pos + 1'b1;
        end
      end
      default: begin
        if (b == CHAR_HASH) begin
          st_pos = '0;
          st_phase = PH_TEXT;
        end else if (b == ADDR_A || b == ADDR_B || b == ADDR_C || b == ADDR_D) begin
          st_phase = PH_CODE;
        end else begin
          st_phase = PH_HUNT;
        end
      end
    endcase
    r.arrival_status = st_arrival;
    r.homing_status  = st_homing;
    r.in_position    = |(st_arrival & IN_POS_MASK);
    r.homing_done    = ((st_homing & HOME_BUSY_MASK) == '0);
    r.pulse_value    = st_pulse;
    r.parser_phase   = st_phase;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_char(input char_kind_e kind);
    int unsigned r;
    char_kind_e  k;
    k = kind;
    if (k == CH_MIXED) begin
      r = $urandom_range(0, 9);
      k = (r < 5) ? CH_DIGIT : (r == 5) ? CH_BLANK : (r == 6) ? CH_SIGN : CH_ANY;
    end
    case (k)
      CH_DIGIT: return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
      CH_BLANK: return ($urandom_range(0, 5) == 0) ? CHAR_SPACE
                                                  : CHAR_TAB + BYTE_W'($urandom_range(0, 4));
      CH_SIGN:  return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
      default:  return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Transfers are sampled at the edge; counters move by nonblocking update so
  // the drivers read a stable value at the same edge.
  always @(posedge clk_i) begin : monitor
    logic         took_in;
    logic         took_out;
    mrpp_result_t want;
    mrpp_result_t got;
    if (rst_ni) begin
      took_in  = rx_if.valid && rx_if.ready;
      took_out = res_if.valid && res_if.ready;
      if (took_in) begin
        want = parse_byte(rx_if.rx_byte);
        if (n_in < DIR_N && DIRECTED[n_in].typed) want = DIRECTED[n_in].want;
        pending_results.push_back(want);
        n_in <= n_in + 1;
      end
      if (took_out) begin
        got = {res_if.arrival_status, res_if.homing_status, res_if.in_position,
               res_if.homing_done, res_if.pulse_value, res_if.pulse_updated,
               res_if.status_updated, res_if.parser_phase};
        if (pending_results.size() == 0) begin
          $error("unexpected result 0x%0h with nothing pending", got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("arrival_status", 16'(want.arrival_status),
                      16'(got.arrival_status));
          check_field("homing_status",  16'(want.homing_status),
                      16'(got.homing_status));
          check_field("in_position",    16'(want.in_position),    16'(got.in_position));
          check_field("homing_done",    16'(want.homing_done),    16'(got.homing_done));
          check_field("pulse_value",    want.pulse_value,         got.pulse_value);
          check_field("pulse_updated",  16'(want.pulse_updated),
                      16'(got.pulse_updated));
          check_field("status_updated", 16'(want.status_updated),
                      16'(got.status_updated));
          check_field("parser_phase",   16'(want.parser_phase),   16'(got.parser_phase));
        end
        n_out <= n_out + 1;
      end
      stuck <= (took_in || took_out) ? 0 : stuck + 1;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off that
  // fills the block and backs up the byte input.
  initial begin : result_sink
    logic held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_in >= HOLD_AT) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (n_in >= CALM_FROM && n_in < CALM_TO) res_if.ready <= 1'b1;
      else res_if.ready <= ($urandom_range(0, 99) >= 33);
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk_i);
      if (stuck >= STUCK_LIMIT) break;
    end
    $display("** motor_reply_and_pulse_packet_parser: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] addrs [4];
    seq_kind_e         seq;
    int unsigned       r;
    int unsigned       wlen;
    int unsigned       k;
    int unsigned       extra;

    addrs = '{ADDR_A, ADDR_B, ADDR_C, ADDR_D};
    rst_ni          <= 1'b0;
    rx_if.valid     <= 1'b0;
    rx_if.rx_byte   <= '0;
    st_phase        = PH_HUNT;
    st_code_homing  = 1'b0;
    st_arrival      = '0;
    st_homing       = '0;
    st_pulse        = '0;
    st_pos          = '0;
    st_win          = '{default: '0};
    n_in            = 0;
    n_out           = 0;
    stuck           = 0;
    mismatches      = 0;

    foreach (DIRECTED[i]) byte_stream.push_back(DIRECTED[i].rx);

    // Random part: mostly well-formed replies and packets with random content,
    // some broken sequences and loose noise.
    while (byte_stream.size() < DIR_N + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      seq = (r < 40) ? SEQ_REPLY : (r < 85) ? SEQ_PACKET : SEQ_NOISE;
      case (seq)
        SEQ_REPLY: begin
          byte_stream.push_back(addrs[$urandom_range(0, 3)]);
          if ($urandom_range(0, 9) == 0) byte_stream.push_back(BYTE_W'($urandom_range(0, 255)));
          else byte_stream.push_back($urandom_range(0, 1) ? CODE_HOMING : CODE_ARRIVE);
          byte_stream.push_back(BYTE_W'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 3)) byte_stream.push_back(BYTE_W'($urandom_range(0, 255)));
          byte_stream.push_back(REPLY_TAIL);
        end
        SEQ_PACKET: begin
          byte_stream.push_back(CHAR_HASH);
          if ($urandom_range(0, 99) < 70) begin
            // prefix, then a number laid into the value window
            repeat (VALUE_START) byte_stream.push_back(BYTE_W'($urandom_range(8'h22, 8'h7E)));
            wlen = ($urandom_range(0, 9) < 6) ? VALUE_LENGTH_DEF : $urandom_range(0, 3);
            k = 0;
            if (k < wlen && $urandom_range(0, 2) == 0) begin
              byte_stream.push_back(pick_char(CH_BLANK));
              k++;
            end
            if (k < wlen && $urandom_range(0, 1) == 0) begin
              byte_stream.push_back(pick_char(CH_SIGN));
              k++;
            end
            while (k < wlen) begin
              byte_stream.push_back(pick_char(CH_DIGIT));
              k++;
            end
            // trailing bytes: usually none, sometimes enough to saturate the position
            r = $urandom_range(0, 9);
            extra = (r < 7) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 14);
            repeat (extra) byte_stream.push_back(pick_char(CH_MIXED));
          end else begin
            repeat ($urandom_range(0, 20)) byte_stream.push_back(pick_char(CH_MIXED));
          end
          if ($urandom_range(0, 19) != 0) byte_stream.push_back(CHAR_BANG);
        end
        default: begin
          repeat ($urandom_range(1, 3)) byte_stream.push_back(BYTE_W'($urandom_range(0, 255)));
        end
      endcase
    end

    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (byte_stream[i]) begin
      while (!(i >= CALM_FROM && i < CALM_TO) && $urandom_range(0, 99) < 33) begin
        rx_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      rx_if.valid   <= 1'b1;
      rx_if.rx_byte <= byte_stream[i];
      do @(posedge clk_i); while (!rx_if.ready);
    end
    rx_if.valid <= 1'b0;
    @(posedge clk_i);

    while (n_out != n_in) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** motor_reply_and_pulse_packet_parser: PASSED **");
    end else begin
      $display("** motor_reply_and_pulse_packet_parser: FAILED **");
    end
    $finish;
  end

endmodule
